>>> hw/rtl/keqpp_pkg.sv
`default_nettype none
package keqpp_pkg;
    localparam int DEPTH     = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = IDX_BITS + 1;
    localparam int TIME_BITS = 32;
    localparam int KEY_BITS  = 16;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_CLEANUP = 2'd2,
        CMD_RESET   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef logic [IDX_BITS-1:0] idx_t;
    typedef logic [CNT_BITS-1:0] cnt_t;
endpackage
`default_nettype wire

>>> hw/rtl/key_event_queue_paired_purge.sv
// Key event queue with paired purge. Input word (s_tdata, 88 bits) carries command, key id,
// press flag, drop flag, now_time and min_time; one result word per input word. The events
// live in one synchronous memory (key, press, time) read one entry per cycle. An enqueue or
// reset goes from idle to the finish state, a dequeue through its read and wait states first.
// Cleanup reads memory in a read state and checks the word in a check state: it scans for
// the stale boundary, then for each stale press scans forward for its release, up to about
// n*n/2 + 2n reads for n held events. An enqueue into a full queue with the drop flag set
// runs one such cleanup per stored event, restarting after every removal, with more restarts
// when the capacity sits far below the fill. A result word waits in an output register; the
// next input word is taken once it is gone. The capacity register is to be written with
// cfg_we/cfg_data only while the block is idle; the block itself does not enforce this.
`default_nettype none
module key_event_queue_paired_purge
    import keqpp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [5:0]   cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command[1:0], key_id[17:2], key_pressed[18], drop_flag[19], now_time[51:20],
    // min_time[83:52], zero fill [87:84]
    input  wire logic [87:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], out_key_id[17:2], out_pressed[18], fill_count[24:19], is_full[25],
    // is_empty[26], purged_count[32:27], zero fill [39:33]
    output logic [39:0]       m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEQ_RD, S_DEQ_WAIT, S_BND_RD, S_BND_CHK, S_WALK_RD, S_WALK_CHK,
        S_PAIR_RD, S_PAIR_CHK, S_DROP_RD, S_DROP_CHK, S_FINISH, S_OUT
    } state_t;

    // event memory
    logic [KEY_BITS-1:0]  key_mem  [DEPTH];
    logic                 prs_mem  [DEPTH];
    logic [TIME_BITS-1:0] time_mem [DEPTH];
    logic                 we;
    idx_t                 waddr, raddr;
    logic [KEY_BITS-1:0]  wkey, rkey;
    logic                 wprs, rprs;
    logic [TIME_BITS-1:0] wtime, rtime;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr]  <= wkey;
            prs_mem[waddr]  <= wprs;
            time_mem[waddr] <= wtime;
        end
        rkey  <= key_mem[raddr];
        rprs  <= prs_mem[raddr];
        rtime <= time_mem[raddr];
    end

    state_t               state_reg;
    logic [5:0]           cap_reg;
    idx_t                 head_reg;
    cnt_t                 cnt_reg;
    logic [1:0]           cmd_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic                 prs_reg, dropmode_reg, incl_reg;
    logic [TIME_BITS-1:0] now_reg, bound_reg;
    cnt_t                 f_reg, cur_reg, j_reg, far_reg, rem_reg, p_reg;
    logic                 far_ok_reg;
    logic [KEY_BITS-1:0]  ckey_reg;
    logic [CNT_BITS:0]    depth_reg;
    logic [5:0]           purged_reg;
    logic [39:0]          out_reg;

    cnt_t cap_eff;
    logic full;
    assign cap_eff = (cap_reg > 6'(DEPTH)) ? cnt_t'(DEPTH) : cnt_t'(cap_reg);
    assign full    = cnt_reg >= cap_eff;

    function automatic idx_t slot(idx_t h, cnt_t p);
        slot = h + p[IDX_BITS-1:0];
    endfunction

    logic stale;
    assign stale = incl_reg ? (rtime <= bound_reg) : (rtime < bound_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg;

    // read address and write port
    always_comb
    begin
        raddr = slot(head_reg, cur_reg);
        case (state_reg)
            S_PAIR_RD: raddr = slot(head_reg, j_reg);
            S_DROP_RD: raddr = slot(head_reg, p_reg);
            default:   raddr = slot(head_reg, cur_reg);
        endcase
        we    = 1'b0;
        waddr = slot(head_reg, cnt_reg);
        wkey  = key_reg;
        wprs  = prs_reg;
        wtime = now_reg;
        if (state_reg == S_FINISH && cmd_reg == CMD_ENQUEUE && !full)
            we = 1'b1;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cap_reg    <= 6'd32;
            head_reg   <= '0;
            cnt_reg    <= '0;
            out_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg    <= s_tdata[1:0];
                        key_reg    <= s_tdata[17:2];
                        prs_reg    <= s_tdata[18];
                        now_reg    <= s_tdata[51:20];
                        bound_reg  <= s_tdata[83:52];
                        purged_reg <= '0;
                        dropmode_reg <= 1'b0;
                        cur_reg    <= '0;
                        case (s_tdata[1:0])
                            CMD_ENQUEUE:
                            begin
                                if (full && s_tdata[19])
                                begin
                                    dropmode_reg <= 1'b1;
                                    p_reg        <= '0;
                                    rem_reg      <= '0;
                                    f_reg        <= '1;
                                    state_reg    <= S_DROP_RD;
                                end
                                else
                                    state_reg <= S_FINISH;
                            end
                            CMD_DEQUEUE: state_reg <= S_DEQ_RD;
                            CMD_CLEANUP:
                            begin
                                incl_reg  <= 1'b0;
                                state_reg <= S_BND_RD;
                            end
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_DEQ_RD: state_reg <= S_DEQ_WAIT;
                S_DEQ_WAIT: state_reg <= S_FINISH;
                // drop: pick next bound
                S_DROP_RD:
                begin
                    if (!full || p_reg >= cnt_reg)
                        state_reg <= S_FINISH;
                    else
                        state_reg <= S_DROP_CHK;
                end
                S_DROP_CHK:
                begin
                    bound_reg <= rtime;
                    incl_reg  <= 1'b1;
                    cur_reg   <= '0;
                    state_reg <= S_BND_RD;
                end
                // find stale boundary f
                S_BND_RD:
                begin
                    if (cur_reg >= cnt_reg)
                    begin
                        f_reg      <= cnt_reg;
                        cur_reg    <= '0;
                        far_ok_reg <= 1'b0;
                        far_reg    <= '0;
                        rem_reg    <= '0;
                        state_reg  <= S_WALK_RD;
                    end
                    else
                        state_reg <= S_BND_CHK;
                end
                S_BND_CHK:
                begin
                    if (!stale)
                    begin
                        f_reg      <= cur_reg;
                        cur_reg    <= '0;
                        far_ok_reg <= 1'b0;
                        far_reg    <= '0;
                        rem_reg    <= '0;
                        state_reg  <= S_WALK_RD;
                    end
                    else
                    begin
                        cur_reg   <= cur_reg + 1'b1;
                        state_reg <= S_BND_RD;
                    end
                end
                // walk stale region
                S_WALK_RD:
                begin
                    if (cur_reg >= f_reg)
                        state_reg <= S_FINISH;
                    else
                        state_reg <= S_WALK_CHK;
                end
                S_WALK_CHK:
                begin
                    if (rprs)
                    begin
                        ckey_reg  <= rkey;
                        depth_reg <= (CNT_BITS+1)'(1);
                        j_reg     <= cur_reg + 1'b1;
                        state_reg <= S_PAIR_RD;
                    end
                    else
                    begin
                        if (!far_ok_reg || cur_reg >= far_reg)
                        begin
                            far_reg    <= cur_reg;
                            far_ok_reg <= 1'b1;
                            rem_reg    <= cur_reg + 1'b1;
                        end
                        cur_reg   <= cur_reg + 1'b1;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_PAIR_RD:
                begin
                    if (j_reg >= f_reg)
                        state_reg <= S_FINISH;
                    else
                        state_reg <= S_PAIR_CHK;
                end
                S_PAIR_CHK:
                begin
                    if (rkey == ckey_reg && !rprs && depth_reg == 1)
                    begin
                        if (!far_ok_reg || j_reg > far_reg)
                        begin
                            far_reg    <= j_reg;
                            far_ok_reg <= 1'b1;
                            if (cur_reg == j_reg)
                                rem_reg <= cur_reg + 1'b1;
                        end
                        else if (cur_reg == far_reg)
                            rem_reg <= cur_reg + 1'b1;
                        cur_reg   <= cur_reg + 1'b1;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        if (rkey == ckey_reg)
                            depth_reg <= rprs ? depth_reg + 1'b1 : depth_reg - 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PAIR_RD;
                    end
                end
                S_FINISH:
                begin
                    if (dropmode_reg && cmd_reg == CMD_ENQUEUE && rem_reg != '0
                        && f_reg != '1)
                    begin
                        // removal from a drop pass: pop, restart scan
                        head_reg   <= slot(head_reg, rem_reg);
                        cnt_reg    <= cnt_reg - rem_reg;
                        purged_reg <= purged_reg + 6'(rem_reg);
                        rem_reg    <= '0;
                        p_reg      <= '0;
                        state_reg  <= S_DROP_RD;
                    end
                    else if (dropmode_reg && cmd_reg == CMD_ENQUEUE && f_reg != '1)
                    begin
                        // this bound freed nothing
                        p_reg     <= p_reg + 1'b1;
                        f_reg     <= '1;
                        state_reg <= S_DROP_RD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        case (cmd_reg)
                            CMD_ENQUEUE:
                            begin
                                out_reg <= {7'd0, purged_reg,
                                    (cnt_reg + (full ? 1'b0 : 1'b1)) == '0,
                                    (cnt_reg + (full ? 1'b0 : 1'b1)) >= cap_eff,
                                    6'(cnt_reg + (full ? 1'b0 : 1'b1)), 1'b0, 16'd0,
                                    full ? ST_NO_SPACE : ST_OK};
                                if (!full)
                                    cnt_reg <= cnt_reg + 1'b1;
                            end
                            CMD_DEQUEUE:
                            begin
                                if (cnt_reg == '0)
                                    out_reg <= {7'd0, 6'd0, 1'b1, (cap_eff == '0),
                                        6'd0, 1'b0, 16'd0, ST_EMPTY};
                                else
                                begin
                                    out_reg <= {7'd0, 6'd0, (cnt_reg == cnt_t'(1)),
                                        (cnt_reg - 1'b1) >= cap_eff, 6'(cnt_reg - 1'b1),
                                        rprs, rkey, ST_OK};
                                    head_reg <= head_reg + 1'b1;
                                    cnt_reg  <= cnt_reg - 1'b1;
                                end
                            end
                            CMD_CLEANUP:
                            begin
                                out_reg <= {7'd0, 6'(rem_reg), (cnt_reg == rem_reg),
                                    (cnt_reg - rem_reg) >= cap_eff,
                                    6'(cnt_reg - rem_reg), 1'b0, 16'd0, ST_OK};
                                head_reg <= slot(head_reg, rem_reg);
                                cnt_reg  <= cnt_reg - rem_reg;
                            end
                            default:
                            begin
                                out_reg <= {7'd0, 6'(cnt_reg), 1'b1, (cap_eff == '0),
                                    6'd0, 1'b0, 16'd0, ST_OK};
                                head_reg <= '0;
                                cnt_reg  <= '0;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cnt_t'(DEPTH)) else $error("count over depth");
    a_hs: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(out_reg)) else $error("result changed");

endmodule
`default_nettype wire
